>>> hw/rtl/rcs_pkg.sv
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared widths, register indexes and lane structs for the region colour
// statistics unit.
// ----------------------------------------------------------------------------
package rcs_pkg;

    localparam int PIX_W       = 8;
    localparam int COORD_W     = 11;
    localparam int SIZE_W      = 12;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_LANES   = 3;
    localparam int SHARE_DEPTH = 1 << PIX_W;
    localparam int DEF_MAX_DIM = 2048;

    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT     = 3'd0,
        CFG_TOP      = 3'd1,
        CFG_WIDTH    = 3'd2,
        CFG_HEIGHT   = 3'd3,
        CFG_MIN_SIZE = 3'd4
    } cfg_index_t;

    // One write into every lane's share table during a fill sweep.
    typedef struct packed {
        logic             en;
        logic [PIX_W-1:0] addr;
        logic [PIX_W-1:0] data;
    } share_wr_t;

    // Per-word control from the front end to the lanes.
    typedef struct packed {
        logic rd_en;   // word accepted: capture channel, read its share
        logic upd;     // stage-one word lies in the region: fold it in
        logic clr;     // stage-one word ends the frame: restore reset values
    } lane_ctrl_t;

    typedef struct packed {
        logic [PIX_W-1:0] max_val;
        logic [PIX_W-1:0] min_val;
        logic [PIX_W-1:0] avg_val;
    } lane_stat_t;

endpackage

>>> hw/rtl/rcs_share_gen.sv
// ----------------------------------------------------------------------------
// rcs_share_gen
// Area product and fill sweep of the rounded-share tables: entry c receives
// round(c / N) with ties to even, built with a running quotient and remainder.
// ----------------------------------------------------------------------------
module rcs_share_gen
    import rcs_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             restart,
    input  logic [$clog2(MAX_DIM+1)-1:0]     eff_w,
    input  logic [$clog2(MAX_DIM+1)-1:0]     eff_h,
    output share_wr_t                        share_wr,
    output logic                             run
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int N_W   = 2 * DIM_W;

    typedef enum logic [2:0] {
        ST_DIM  = 3'b001,
        ST_FILL = 3'b010,
        ST_RUN  = 3'b100
    } gen_state_t;

    gen_state_t       state_reg, state_next;
    logic [N_W-1:0]   n_reg, n_next;
    logic [PIX_W-1:0] cnt_reg, cnt_next;
    logic [PIX_W-1:0] q_reg, q_next;
    logic [PIX_W-1:0] r_reg, r_next;
    logic [PIX_W:0]   r_inc;
    logic [PIX_W:0]   two_r;
    logic             round_up;

    assign r_inc    = {1'b0, r_reg} + 1'b1;
    assign two_r    = {r_reg, 1'b0};
    assign round_up = (N_W'(two_r) > n_reg) || ((N_W'(two_r) == n_reg) && q_reg[0]);

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        case (state_reg)
            ST_DIM: begin
                n_next     = N_W'(eff_w) * N_W'(eff_h);
                cnt_next   = '0;
                q_next     = '0;
                r_next     = '0;
                state_next = ST_FILL;
            end
            ST_FILL: begin
                cnt_next = cnt_reg + 1'b1;
                if (N_W'(r_inc) == n_reg) begin
                    r_next = '0;
                    q_next = q_reg + 1'b1;
                end else begin
                    r_next = r_inc[PIX_W-1:0];
                end
                if (cnt_reg == PIX_MAX) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                state_next = ST_RUN;
            end
            default: begin
                state_next = ST_DIM;
            end
        endcase
        if (restart) begin
            state_next = ST_DIM;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_DIM;
        end else begin
            state_reg <= state_next;
        end
        n_reg   <= n_next;
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
    end

    assign share_wr.en   = (state_reg == ST_FILL);
    assign share_wr.addr = cnt_reg;
    assign share_wr.data = q_reg + PIX_W'(round_up);
    assign run           = (state_reg == ST_RUN);

endmodule

>>> hw/rtl/rcs_lane.sv
// ----------------------------------------------------------------------------
// rcs_lane
// One colour channel: share table, running maximum, minimum and saturating
// average.
// ----------------------------------------------------------------------------
module rcs_lane
    import rcs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  share_wr_t        share_wr,
    input  lane_ctrl_t       ctrl,
    input  logic [PIX_W-1:0] pix,
    output lane_stat_t       stat
);

    logic [PIX_W-1:0] share_mem [SHARE_DEPTH];
    logic [PIX_W-1:0] share_q;
    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] max_reg, max_next;
    logic [PIX_W-1:0] min_reg, min_next;
    logic [PIX_W-1:0] avg_reg, avg_next;
    logic [PIX_W:0]   avg_sum;

    always_ff @(posedge aclk) begin
        if (share_wr.en) begin
            share_mem[share_wr.addr] <= share_wr.data;
        end
        if (ctrl.rd_en) begin
            share_q <= share_mem[pix];
            pix_reg <= pix;
        end
    end

    assign avg_sum = {1'b0, avg_reg} + {1'b0, share_q};

    always_comb begin
        max_next = max_reg;
        min_next = min_reg;
        avg_next = avg_reg;
        if (ctrl.upd) begin
            if (pix_reg > max_reg) max_next = pix_reg;
            if (pix_reg < min_reg) min_next = pix_reg;
            avg_next = avg_sum[PIX_W] ? PIX_MAX : avg_sum[PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clr) begin
            max_reg <= '0;
            min_reg <= PIX_MAX;
            avg_reg <= '0;
        end else begin
            max_reg <= max_next;
            min_reg <= min_next;
            avg_reg <= avg_next;
        end
    end

    assign stat.max_val = max_next;
    assign stat.min_val = min_next;
    assign stat.avg_val = avg_next;

endmodule

>>> hw/rtl/rcs_merge.sv
// ----------------------------------------------------------------------------
// rcs_merge
// Result register: gathers the three lanes' figures at frame end and holds
// them until the downstream side takes the word.
// ----------------------------------------------------------------------------
module rcs_merge
    import rcs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  lane_stat_t stat_in  [NUM_LANES],
    input  logic       m_ready,
    output logic       m_valid,
    output lane_stat_t stat_out [NUM_LANES]
);

    logic       valid_reg;
    lane_stat_t stat_reg [NUM_LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
        if (load) begin
            stat_reg <= stat_in;
        end
    end

    assign m_valid  = valid_reg;
    assign stat_out = stat_reg;

endmodule

>>> hw/rtl/region_color_statistics_unit.sv
// ----------------------------------------------------------------------------
// region_color_statistics_unit
// Per-channel maximum, minimum and rounded-share average of the pixels that
// fall inside a configured rectangle; one result word per frame.
// ----------------------------------------------------------------------------
//
//  port group     | direction | handshake         | payload
//  ---------------+-----------+-------------------+-------------------------------
//  s_  pixel      | in        | s_valid / s_ready | chan0..2, pixel_col/row, frame_end
//  m_  statistics | out       | m_valid / m_ready | max0..2, min0..2, avg0..2
//  cfg_wr_        | in        | cfg_wr_en only    | cfg_wr_index, cfg_wr_data
//
//  One pixel word per cycle once running, except while a frame-end word stalls;
//  a frame's result passes through stage one and waits in the result register.
//  After reset and after every register write a fill sweep (area product,
//  then one share-table entry per cycle) holds s_ready low.
//  A frame-end word stalls in stage one only while an earlier result is still
//  unclaimed; ordinary pixels keep flowing past a waiting result.
//
module region_color_statistics_unit
    import rcs_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_chan0,
    input  logic [PIX_W-1:0]      s_chan1,
    input  logic [PIX_W-1:0]      s_chan2,
    input  logic [COORD_W-1:0]    s_pixel_col,
    input  logic [COORD_W-1:0]    s_pixel_row,
    input  logic                  s_frame_end,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_max0,
    output logic [PIX_W-1:0]      m_max1,
    output logic [PIX_W-1:0]      m_max2,
    output logic [PIX_W-1:0]      m_min0,
    output logic [PIX_W-1:0]      m_min1,
    output logic [PIX_W-1:0]      m_min2,
    output logic [PIX_W-1:0]      m_avg0,
    output logic [PIX_W-1:0]      m_avg1,
    output logic [PIX_W-1:0]      m_avg2
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (DIM_W > SIZE_W) ? DIM_W : SIZE_W;
    localparam int EDG_W = ((DIM_W > COORD_W) ? DIM_W : COORD_W) + 1;

    // Configuration registers
    logic [COORD_W-1:0] left_reg;
    logic [COORD_W-1:0] top_reg;
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [SIZE_W-1:0]  min_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg     <= '0;
            top_reg      <= '0;
            width_reg    <= SIZE_W'(1);
            height_reg   <= SIZE_W'(1);
            min_size_reg <= SIZE_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_LEFT:     left_reg     <= cfg_wr_data[COORD_W-1:0];
                CFG_TOP:      top_reg      <= cfg_wr_data[COORD_W-1:0];
                CFG_WIDTH:    width_reg    <= cfg_wr_data[SIZE_W-1:0];
                CFG_HEIGHT:   height_reg   <= cfg_wr_data[SIZE_W-1:0];
                CFG_MIN_SIZE: min_size_reg <= cfg_wr_data[SIZE_W-1:0];
                default: ;   // drop writes to unused indexes
            endcase
        end
    end

    // Effective side: raise to min_size and to one, cap at MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [SIZE_W-1:0] req,
                                                 input logic [SIZE_W-1:0] floor_val);
        logic [SIZE_W-1:0] d;
        d = (req > floor_val) ? req : floor_val;
        if (d == '0) d = SIZE_W'(1);
        if (CMP_W'(d) > CMP_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(d);
    endfunction

    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;

    assign eff_w = eff_dim(width_reg, min_size_reg);
    assign eff_h = eff_dim(height_reg, min_size_reg);

    // Region test on the incoming word; the right and bottom edges are exclusive.
    logic [EDG_W-1:0] right_edge;
    logic [EDG_W-1:0] bottom_edge;
    logic             in_rect;

    assign right_edge  = EDG_W'(left_reg) + EDG_W'(eff_w);
    assign bottom_edge = EDG_W'(top_reg) + EDG_W'(eff_h);
    assign in_rect     = (s_pixel_col >= left_reg) && (EDG_W'(s_pixel_col) < right_edge) &&
                         (s_pixel_row >= top_reg) && (EDG_W'(s_pixel_row) < bottom_edge);

    // Share tables: rebuilt whenever the region may have changed size.
    share_wr_t share_wr;
    logic      run;

    rcs_share_gen #(
        .MAX_DIM (MAX_DIM)
    ) u_share_gen (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .restart  (cfg_wr_en),
        .eff_w    (eff_w),
        .eff_h    (eff_h),
        .share_wr (share_wr),
        .run      (run)
    );

    // Stage one: the accepted word while its shares are read from the tables.
    logic s1_valid_reg;
    logic s1_inside_reg;
    logic s1_last_reg;
    logic stall;
    logic accept;
    logic adv;

    // Hold a frame-end word while the previous result is still unclaimed.
    assign stall   = s1_valid_reg && s1_last_reg && m_valid && !m_ready;
    assign s_ready = run && !stall;
    assign accept  = s_valid && s_ready;
    assign adv     = s1_valid_reg && !stall;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (!stall) begin
            s1_valid_reg <= accept;
        end
        if (accept) begin
            s1_inside_reg <= in_rect;
            s1_last_reg   <= s_frame_end;
        end
    end

    lane_ctrl_t ctrl;

    assign ctrl.rd_en = accept;
    assign ctrl.upd   = adv && s1_inside_reg;
    assign ctrl.clr   = adv && s1_last_reg;

    // Lanes: one per colour channel, all fed by the same control.
    logic [PIX_W-1:0] lane_pix  [NUM_LANES];
    lane_stat_t       lane_stat [NUM_LANES];
    lane_stat_t       res_stat  [NUM_LANES];

    assign lane_pix[0] = s_chan0;
    assign lane_pix[1] = s_chan1;
    assign lane_pix[2] = s_chan2;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        rcs_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .share_wr (share_wr),
            .ctrl     (ctrl),
            .pix      (lane_pix[g]),
            .stat     (lane_stat[g])
        );
    end

    // Merge: capture all lanes' figures as the frame-end word folds in.
    rcs_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (ctrl.clr),
        .stat_in  (lane_stat),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .stat_out (res_stat)
    );

    assign m_max0 = res_stat[0].max_val;
    assign m_max1 = res_stat[1].max_val;
    assign m_max2 = res_stat[2].max_val;
    assign m_min0 = res_stat[0].min_val;
    assign m_min1 = res_stat[1].min_val;
    assign m_min2 = res_stat[2].min_val;
    assign m_avg0 = res_stat[0].avg_val;
    assign m_avg1 = res_stat[1].avg_val;
    assign m_avg2 = res_stat[2].avg_val;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// region_color_statistics_unit testbench
// Streams pixel words through the unit under several region settings and
// checks every statistics word against the directed table's expectation or a
// cycle-free model of the unit that runs alongside the stimulus.
// ----------------------------------------------------------------------------
module tb
    import rcs_pkg::*;
();

    localparam int ITEM_TARGET   = 1750;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 6;    // stage-one word plus result register, with margin
    localparam int TAIL_CYCLES   = 12;
    localparam int LONG_HOLD     = 500;  // receiver hold-off that backs the unit up
    localparam int COORD_MAX     = (1 << COORD_W) - 1;

    // Register indexes the unit does not decode; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [NUM_LANES-1:0][PIX_W-1:0] chan;
        logic [COORD_W-1:0]              col;
        logic [COORD_W-1:0]              row;
        logic                            last;
    } pixel_t;

    typedef struct packed {
        logic [NUM_LANES-1:0][PIX_W-1:0] max_v;
        logic [NUM_LANES-1:0][PIX_W-1:0] min_v;
        logic [NUM_LANES-1:0][PIX_W-1:0] avg_v;
    } stats_t;

    typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

    // One line of the directed table: a register write or a pixel word, the
    // latter optionally carrying the statistics word it must produce.
    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        pixel_t                px;
        bit                    has_exp;
        stats_t                exp;
    } stim_row_t;

    typedef enum int {
        MODE_SMALL,   // tiny rectangle, averages build up fast
        MODE_FLOOR,   // requested size below min_size
        MODE_HUGE,    // every size register at its top, capped area
        MODE_CORNER,  // far corner of the frame, zero sizes
        MODE_WILD,    // every register bit random
        MODE_MEDIUM   // mid-sized area, rounding of small shares
    } region_mode_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the unit
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;

    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [PIX_W-1:0]   s_chan0     = '0;
    logic [PIX_W-1:0]   s_chan1     = '0;
    logic [PIX_W-1:0]   s_chan2     = '0;
    logic [COORD_W-1:0] s_pixel_col = '0;
    logic [COORD_W-1:0] s_pixel_row = '0;
    logic               s_frame_end = 1'b0;

    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [PIX_W-1:0] m_max0, m_max1, m_max2;
    logic [PIX_W-1:0] m_min0, m_min1, m_min2;
    logic [PIX_W-1:0] m_avg0, m_avg1, m_avg2;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    region_color_statistics_unit #(
        .MAX_DIM (DEF_MAX_DIM)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_chan0      (s_chan0),
        .s_chan1      (s_chan1),
        .s_chan2      (s_chan2),
        .s_pixel_col  (s_pixel_col),
        .s_pixel_row  (s_pixel_row),
        .s_frame_end  (s_frame_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_max0       (m_max0),
        .m_max1       (m_max1),
        .m_max2       (m_max2),
        .m_min0       (m_min0),
        .m_min1       (m_min1),
        .m_min2       (m_min2),
        .m_avg0       (m_avg0),
        .m_avg1       (m_avg1),
        .m_avg2       (m_avg2)
    );

    // ------------------------------------------------------------------------
    // Model of the unit: register copies and the per-lane running store
    // ------------------------------------------------------------------------
    logic [COORD_W-1:0] reg_left     = '0;
    logic [COORD_W-1:0] reg_top      = '0;
    logic [SIZE_W-1:0]  reg_width    = 12'd1;
    logic [SIZE_W-1:0]  reg_height   = 12'd1;
    logic [SIZE_W-1:0]  reg_min_size = 12'd1;

    logic [PIX_W-1:0] run_max [NUM_LANES];
    logic [PIX_W-1:0] run_min [NUM_LANES];
    logic [PIX_W-1:0] run_avg [NUM_LANES];

    stats_t    pending_stats [$];   // statistics words still owed by the unit
    stim_row_t directed_rows [$];

    int  sent_items     = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  tx_quiet       = 1'b0;
    bit  rx_quiet       = 1'b0;
    int  hold_requests  = 0;
    int  holds_taken    = 0;
    int  rx_hold        = 0;
    int  rx_gap;

    function automatic void clear_store();
        for (int k = 0; k < NUM_LANES; k++) begin
            run_max[k] = '0;
            run_min[k] = PIX_MAX;
            run_avg[k] = '0;
        end
    endfunction

    // Requested size, raised to min_size and to one, capped at the frame limit.
    function automatic int unsigned clamp_dim(logic [SIZE_W-1:0] req);
        int unsigned d;
        d = 32'((req > reg_min_size) ? req : reg_min_size);
        if (d < 1) d = 1;
        if (d > DEF_MAX_DIM) d = DEF_MAX_DIM;
        return d;
    endfunction

    // c / area rounded to nearest, halves going to the even neighbour.
    function automatic int unsigned share_of(int unsigned c, int unsigned area);
        int unsigned q, r;
        q = c / area;
        r = c % area;
        if (2 * r > area || (2 * r == area && q[0])) q++;
        return q;
    endfunction

    function automatic bit in_region(pixel_t p);
        int unsigned w, h;
        w = clamp_dim(reg_width);
        h = clamp_dim(reg_height);
        return p.col >= reg_left && p.col < reg_left + w &&
               p.row >= reg_top && p.row < reg_top + h;
    endfunction

    // Fold one accepted pixel word into the store; on a frame end hand back
    // the statistics word and restore the store.
    function automatic bit fold_pixel(pixel_t p, output stats_t res);
        int unsigned area, sum;
        area = clamp_dim(reg_width) * clamp_dim(reg_height);
        res  = '0;
        if (in_region(p)) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                if (p.chan[k] > run_max[k]) run_max[k] = p.chan[k];
                if (p.chan[k] < run_min[k]) run_min[k] = p.chan[k];
                sum = run_avg[k] + share_of(32'(p.chan[k]), area);
                run_avg[k] = (sum > PIX_MAX) ? PIX_MAX : sum[PIX_W-1:0];
            end
        end
        if (!p.last) return 1'b0;
        for (int k = 0; k < NUM_LANES; k++) begin
            res.max_v[k] = run_max[k];
            res.min_v[k] = run_min[k];
            res.avg_v[k] = run_avg[k];
        end
        clear_store();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------------
    function automatic stats_t make_stats(int x0, int x1, int x2,
                                          int n0, int n1, int n2,
                                          int a0, int a1, int a2);
        stats_t s;
        s.max_v = {PIX_W'(x2), PIX_W'(x1), PIX_W'(x0)};
        s.min_v = {PIX_W'(n2), PIX_W'(n1), PIX_W'(n0)};
        s.avg_v = {PIX_W'(a2), PIX_W'(a1), PIX_W'(a0)};
        return s;
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        stim_row_t r;
        r         = '{kind: ROW_CFG, default: '0};
        r.idx     = idx;
        r.data    = data;
        r.has_exp = 1'b0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_pix(logic [PIX_W-1:0] c0, logic [PIX_W-1:0] c1,
                                    logic [PIX_W-1:0] c2, int col, int row, logic last);
        stim_row_t r;
        r         = '{kind: ROW_PIX, default: '0};
        r.px.chan = {c2, c1, c0};
        r.px.col  = COORD_W'(col);
        r.px.row  = COORD_W'(row);
        r.px.last = last;
        r.has_exp = 1'b0;
        directed_rows.push_back(r);
    endfunction

    // Frame-end word whose statistics can be read straight off the table.
    function automatic void add_chk(logic [PIX_W-1:0] c0, logic [PIX_W-1:0] c1,
                                    logic [PIX_W-1:0] c2, int col, int row, stats_t exp);
        add_pix(c0, c1, c2, col, row, 1'b1);
        directed_rows[$].has_exp = 1'b1;
        directed_rows[$].exp     = exp;
    endfunction

    // ------------------------------------------------------------------------
    // Random draws
    // ------------------------------------------------------------------------
    // Idle length: mostly none or short, now and then a long one.
    function automatic int draw_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PIX_W-1:0] draw_chan();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return PIX_MAX;
        return PIX_W'($urandom_range(0, PIX_MAX));
    endfunction

    // Coordinate aimed at the span [lo, lo+span), its edges, or anywhere.
    function automatic logic [COORD_W-1:0] draw_coord(int unsigned lo, int unsigned span);
        int unsigned hi;
        int          r;
        hi = lo + span - 1;
        if (hi > COORD_MAX) hi = COORD_MAX;
        r = $urandom_range(0, 99);
        if (r < 70) return COORD_W'($urandom_range(lo, hi));
        if (r < 78 && lo > 0) return COORD_W'(lo - 1);
        if (r < 86 && hi < COORD_MAX) return COORD_W'(hi + 1);
        return COORD_W'($urandom_range(0, COORD_MAX));
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Offer one word, hold it until taken, then model it and maybe idle.
    task automatic send_pixel(pixel_t p, bit has_exp, stats_t typed);
        stats_t res;
        int     gap;
        s_valid     <= 1'b1;
        s_chan0     <= p.chan[0];
        s_chan1     <= p.chan[1];
        s_chan2     <= p.chan[2];
        s_pixel_col <= p.col;
        s_pixel_row <= p.row;
        s_frame_end <= p.last;
        do @(posedge aclk); while (!s_ready);
        sent_items++;
        if (fold_pixel(p, res)) pending_stats.push_back(has_exp ? typed : res);
        if (!tx_quiet) begin
            gap = draw_idle();
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Drop valid and let the unit drain before touching its registers.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves the write enable high so back-to-back writes need no gap;
    // the caller drops it after the last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        case (idx)
            CFG_LEFT:     reg_left     = data[COORD_W-1:0];
            CFG_TOP:      reg_top      = data[COORD_W-1:0];
            CFG_WIDTH:    reg_width    = data;
            CFG_HEIGHT:   reg_height   = data;
            CFG_MIN_SIZE: reg_min_size = data;
            default: ;
        endcase
    endtask

    task automatic program_region(region_mode_t mode);
        logic [CFG_DATA_W-1:0] left_v, top_v, width_v, height_v, floor_v;
        left_v   = CFG_DATA_W'($urandom_range(0, COORD_MAX));
        top_v    = CFG_DATA_W'($urandom_range(0, COORD_MAX));
        width_v  = CFG_DATA_W'($urandom_range(1, 4));
        height_v = CFG_DATA_W'($urandom_range(1, 4));
        floor_v  = CFG_DATA_W'($urandom_range(0, 3));
        case (mode)
            MODE_FLOOR: begin
                width_v  = CFG_DATA_W'($urandom_range(0, 3));
                height_v = CFG_DATA_W'($urandom_range(0, 3));
                floor_v  = CFG_DATA_W'($urandom_range(2, 6));
            end
            MODE_HUGE: begin
                left_v   = '0;
                top_v    = '0;
                width_v  = '1;
                height_v = '1;
                floor_v  = '1;
            end
            MODE_CORNER: begin
                left_v   = CFG_DATA_W'(COORD_MAX);
                top_v    = CFG_DATA_W'(COORD_MAX);
                width_v  = '0;
                height_v = '0;
                floor_v  = '0;
            end
            MODE_WILD: begin
                left_v   = CFG_DATA_W'($urandom_range(0, 12'hFFF));
                top_v    = CFG_DATA_W'($urandom_range(0, 12'hFFF));
                width_v  = CFG_DATA_W'($urandom_range(0, 12'hFFF));
                height_v = CFG_DATA_W'($urandom_range(0, 12'hFFF));
                floor_v  = CFG_DATA_W'($urandom_range(0, 12'hFFF));
            end
            MODE_MEDIUM: begin
                width_v  = CFG_DATA_W'($urandom_range(8, 40));
                height_v = CFG_DATA_W'($urandom_range(8, 40));
                floor_v  = CFG_DATA_W'($urandom_range(1, 8));
            end
            default: ;
        endcase
        write_reg(CFG_LEFT, left_v);
        write_reg(CFG_TOP, top_v);
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                      CFG_DATA_W'($urandom_range(0, 12'hFFF)));
        write_reg(CFG_WIDTH, width_v);
        write_reg(CFG_HEIGHT, height_v);
        write_reg(CFG_MIN_SIZE, floor_v);
        cfg_wr_en <= 1'b0;
    endtask

    // One frame: mostly aimed at the rectangle, now and then scattered so the
    // region is likely to stay empty. Lengths are mostly short.
    task automatic send_frame();
        pixel_t p;
        stats_t none;
        int     len;
        bit     aimed;
        none  = '0;
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
        aimed = $urandom_range(0, 99) < 85;
        for (int i = 0; i < len; i++) begin
            for (int k = 0; k < NUM_LANES; k++) p.chan[k] = draw_chan();
            if (aimed) begin
                p.col = draw_coord(32'(reg_left), clamp_dim(reg_width));
                p.row = draw_coord(32'(reg_top), clamp_dim(reg_height));
            end else begin
                p.col = COORD_W'($urandom_range(0, COORD_MAX));
                p.row = COORD_W'($urandom_range(0, COORD_MAX));
            end
            p.last = (i == len - 1);
            send_pixel(p, 1'b0, none);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------------
    function automatic void compare_field(string name, int lane,
                                          logic [PIX_W-1:0] want, logic [PIX_W-1:0] seen);
        if (seen !== want) begin
            $display("%0t: %s%0d expected %0d, got %0d", $time, name, lane, want, seen);
            mismatch_count++;
        end
    endfunction

    task automatic check_stats();
        stats_t seen, want;
        seen.max_v = {m_max2, m_max1, m_max0};
        seen.min_v = {m_min2, m_min1, m_min0};
        seen.avg_v = {m_avg2, m_avg1, m_avg0};
        if (pending_stats.size() == 0) begin
            $display("%0t: statistics word expected none, got %h", $time, seen);
            mismatch_count++;
            return;
        end
        want = pending_stats.pop_front();
        for (int k = 0; k < NUM_LANES; k++) begin
            compare_field("max", k, want.max_v[k], seen.max_v[k]);
            compare_field("min", k, want.min_v[k], seen.min_v[k]);
            compare_field("avg", k, want.avg_v[k], seen.avg_v[k]);
        end
    endtask

    // Check the word taken at this edge, then pick ready for the next one.
    // A long hold-off asked for by the stimulus overrides the random stalls.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_stats();
        if (holds_taken != hold_requests) begin
            holds_taken = hold_requests;
            rx_hold     = LONG_HOLD;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else begin
            rx_gap = rx_quiet ? 0 : draw_idle();
            if (rx_gap > 0) begin
                rx_hold = rx_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("region_color_statistics_unit regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        stats_t empty_stats;
        int     phase;

        clear_store();
        empty_stats = make_stats(0, 0, 0, 255, 255, 255, 0, 0, 0);

        // Reset registers: a 1x1 rectangle at the origin, so each share is
        // the whole channel value and a second word saturates the average.
        add_pix(8'd255, 8'd0, 8'd128, 0, 0, 1'b0);
        add_chk(8'd0, 8'd255, 8'd0, 1, 0,
                make_stats(255, 0, 128, 255, 0, 128, 255, 0, 128));
        add_chk(8'd9, 8'd9, 8'd9, 5, 5, empty_stats);
        add_chk(8'd0, 8'd0, 8'd0, 0, 0, make_stats(0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_pix(8'd255, 8'd255, 8'd255, 0, 0, 1'b0);
        add_pix(8'd1, 8'd2, 8'd3, 0, 0, 1'b0);
        add_chk(8'd0, 8'd0, 8'd0, 0, 1,
                make_stats(255, 255, 255, 1, 2, 3, 255, 255, 255));
        // Area of two: odd values land on halves and round to even.
        add_cfg(CFG_WIDTH, 12'd2);
        add_pix(8'd1, 8'd3, 8'd5, 0, 0, 1'b0);
        add_pix(8'd2, 8'd4, 8'd6, 1, 0, 1'b1);
        // Undecoded index must be dropped; zero sizes fall back to one.
        add_cfg(CFG_SPARE_LAST, 12'hFFF);
        add_cfg(CFG_MIN_SIZE, 12'd0);
        add_cfg(CFG_WIDTH, 12'd0);
        add_cfg(CFG_HEIGHT, 12'd0);
        add_chk(8'd10, 8'd20, 8'd30, 0, 0, make_stats(10, 20, 30, 10, 20, 30, 10, 20, 30));
        add_chk(8'd10, 8'd20, 8'd30, 1, 0, empty_stats);
        // Far corner with capped sizes: the rectangle runs off the frame and
        // the huge area rounds every share to zero. Left's top bit is masked.
        add_cfg(CFG_LEFT, 12'hFFF);
        add_cfg(CFG_TOP, 12'h7FF);
        add_cfg(CFG_WIDTH, 12'hFFF);
        add_cfg(CFG_HEIGHT, 12'hFFF);
        add_cfg(CFG_MIN_SIZE, 12'd1);
        add_pix(8'd200, 8'd100, 8'd50, 2047, 2047, 1'b0);
        add_chk(8'd0, 8'd0, 8'd0, 2046, 2047, make_stats(200, 100, 50, 200, 100, 50, 0, 0, 0));
        // Minimum size dominates and is itself capped.
        add_cfg(CFG_LEFT, 12'd0);
        add_cfg(CFG_TOP, 12'd0);
        add_cfg(CFG_WIDTH, 12'd1);
        add_cfg(CFG_HEIGHT, 12'd1);
        add_cfg(CFG_MIN_SIZE, 12'hFFF);
        add_chk(8'd7, 8'd8, 8'd9, 2047, 2047, make_stats(7, 8, 9, 7, 8, 9, 0, 0, 0));
        // Area of nine from the minimum size.
        add_cfg(CFG_MIN_SIZE, 12'd3);
        add_pix(8'd4, 8'd5, 8'd13, 2, 2, 1'b0);
        add_pix(8'd255, 8'd255, 8'd255, 3, 2, 1'b0);
        add_pix(8'd200, 8'd0, 8'd100, 0, 0, 1'b1);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the table; registers are only touched once the unit has drained.
        for (int k = 0; k < directed_rows.size(); k++) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                if (k == 0 || directed_rows[k-1].kind != ROW_CFG) wait_idle();
                write_reg(directed_rows[k].idx, directed_rows[k].data);
                if (k + 1 == directed_rows.size() || directed_rows[k+1].kind != ROW_CFG)
                    cfg_wr_en <= 1'b0;
            end else begin
                send_pixel(directed_rows[k].px, directed_rows[k].has_exp, directed_rows[k].exp);
            end
        end

        // Random phases: fresh region each phase, extremes first. Some phases
        // run one side flat out; two of them back the result side up hard.
        phase = 0;
        while (sent_items < ITEM_TARGET) begin
            wait_idle();
            program_region(phase <= MODE_MEDIUM ? region_mode_t'(phase)
                                                : region_mode_t'($urandom_range(0, 5)));
            tx_quiet = (phase % 4 == 2);
            rx_quiet = (phase % 4 == 3);
            if (phase == 1 || phase == 6) hold_requests++;
            repeat ($urandom_range(15, 30)) send_frame();
            phase++;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("region_color_statistics_unit regression: pass");
        else
            $display("region_color_statistics_unit regression: fail");
        $finish;
    end

endmodule
